// ===== design/multilevel_priority_run_queue_defines.svh =====
// Assertion macros shared by the run queue checker.
// Depends on nothing; included by files that hold assertions.
`ifndef MULTILEVEL_PRIORITY_RUN_QUEUE_DEFINES_SVH
`define MULTILEVEL_PRIORITY_RUN_QUEUE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MPRQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mprq_pkg.sv =====
// Package for the multilevel priority run queue.
// Holds operation and status codes, controller states and the command and status structs.
package mprq_pkg;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_SELECT   = 3'd1,
        OP_ROTATE   = 3'd2,
        OP_CANCEL   = 3'd3,
        OP_COMPLETE = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNLINK,
        S_LINK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic unlink;
        logic link;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_unlink;
        logic need_link;
    } sts_t;

endpackage

// ===== design/multilevel_priority_run_queue.sv =====
// Top level of the multilevel priority run queue.
// Depends on mprq_pkg, mprq_ctrl and mprq_datapath.
//
//  channel  | direction | content
//  s_axis   | in        | command: operation, level, target_id
//  m_axis   | out       | result: status, slot, ids, counters
//
// Each command passes through load and search, unlink, link, result.
// The result is held in m_axis until taken; the next command is accepted
// after the result leaves. Reset is asynchronous and empties all levels.
module multilevel_priority_run_queue #(
    parameter int SLOTS  = 8,
    parameter int LEVELS = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], level[4:3], target_id[20:5], zero pad
    input  logic [23:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], slot[4:2], task_id[20:5], task_switches[36:21],
    // running_valid[37], running_slot[40:38], total_switches[56:41],
    // completed_count[72:57], active_count[76:73], zero pad
    output logic [79:0]  m_axis_tdata
);
    import mprq_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic in_fire;
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [15:0] task_id;
    logic [15:0] task_switches;
    logic        running_valid;
    logic [2:0]  running_slot;
    logic [15:0] total_switches;
    logic [15:0] completed_count;
    logic [3:0]  active_count;
    logic        out_state;
    logic        sts_out_q;
    logic [1:0]  phase_reg;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    mprq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (m_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    mprq_datapath #(
        .SLOTS  (SLOTS),
        .LEVELS (LEVELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (s_axis_tdata[2:0]),
        .level           (s_axis_tdata[4:3]),
        .target_id       (s_axis_tdata[20:5]),
        .status          (status),
        .slot            (slot),
        .task_id         (task_id),
        .task_switches   (task_switches),
        .running_valid   (running_valid),
        .running_slot    (running_slot),
        .total_switches  (total_switches),
        .completed_count (completed_count),
        .active_count    (active_count)
    );

    assign out_state     = busy && !cmd.unlink && !cmd.link && sts_out_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= 2'd1;
        end
        else if (phase_reg == 2'd1 || phase_reg == 2'd2)
        begin
            phase_reg <= phase_reg + 2'd1;
        end
        else if (phase_reg == 2'd3 && m_axis_tready)
        begin
            phase_reg <= 2'd0;
        end
    end

    assign sts_out_q     = (phase_reg == 2'd3);
    assign m_axis_tvalid = out_state;
    assign m_axis_tdata  = {3'd0, active_count, completed_count, total_switches,
                            running_slot, running_valid, task_switches, task_id,
                            slot, status};

endmodule

// ===== design/mprq_ctrl.sv =====
// Controller state machine of the run queue.
// Depends on mprq_pkg; drives the datapath by commands.
module mprq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_free,
    input  mprq_pkg::sts_t  sts,
    output mprq_pkg::cmd_t  cmd,
    output logic            busy
);
    import mprq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK: state_next = S_LINK;
            S_LINK:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = in_fire;
            end
            S_UNLINK: cmd.unlink = sts.need_unlink;
            S_LINK:   cmd.link = sts.need_link;
            S_OUT:    cmd.finish = out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== design/mprq_datapath.sv =====
// Datapath of the run queue: slot table, level lists and counters.
// Depends on mprq_pkg; commanded by mprq_ctrl.
module mprq_datapath #(
    parameter int SLOTS  = 8,
    parameter int LEVELS = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mprq_pkg::cmd_t  cmd,
    output mprq_pkg::sts_t  sts,
    input  logic [2:0]      operation,
    input  logic [1:0]      level,
    input  logic [15:0]     target_id,
    output logic [1:0]      status,
    output logic [2:0]      slot,
    output logic [15:0]     task_id,
    output logic [15:0]     task_switches,
    output logic            running_valid,
    output logic [2:0]      running_slot,
    output logic [15:0]     total_switches,
    output logic [15:0]     completed_count,
    output logic [3:0]      active_count
);
    import mprq_pkg::*;

    localparam int PW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] NONE = PW'(SLOTS);

    logic [SLOTS-1:0]  used_reg;
    logic [15:0]       tid_reg [SLOTS];
    logic [LW-1:0]     lvl_reg [SLOTS];
    logic [PW-1:0]     prev_reg [SLOTS];
    logic [PW-1:0]     next_reg [SLOTS];
    logic [15:0]       sw_reg [SLOTS];
    logic [PW-1:0]     head_reg [LEVELS];
    logic [PW-1:0]     tail_reg [LEVELS];
    logic [CW-1:0]     lcnt_reg [LEVELS];
    logic [15:0]       nid_reg;
    logic [PW-1:0]     run_reg;
    logic [15:0]       swt_reg;
    logic [15:0]       ret_reg;
    logic [CW-1:0]     live_reg;

    logic [2:0]        op_reg;
    logic [SW-1:0]     s_reg;
    logic [LW-1:0]     lv_reg;
    logic [1:0]        st_reg;
    logic              unl_reg;
    logic              lnk_reg;
    logic              rel_reg;

    logic [SW-1:0]     free_idx;
    logic              free_ok;
    logic [SW-1:0]     hit_idx;
    logic              hit_ok;
    logic [SW-1:0]     head_idx;
    logic              head_ok;
    logic [LW-1:0]     add_lv;
    logic              run_ok;
    logic [SW-1:0]     run_idx;

    assign run_idx = run_reg[SW-1:0];
    assign run_ok  = (run_reg < NONE) && used_reg[run_idx];
    assign add_lv  = (32'(level) >= LEVELS) ? LW'(LEVELS - 1) : LW'(level);

    always_comb
    begin
        free_idx = '0;
        free_ok  = 1'b0;
        hit_idx  = '0;
        hit_ok   = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SW'(i);
                free_ok  = 1'b1;
            end
            if (used_reg[i] && tid_reg[i] == target_id)
            begin
                hit_idx = SW'(i);
                hit_ok  = 1'b1;
            end
        end
        head_idx = '0;
        head_ok  = 1'b0;
        for (int j = LEVELS - 1; j >= 0; j--)
        begin
            if (head_reg[j] < NONE)
            begin
                head_idx = head_reg[j][SW-1:0];
                head_ok  = 1'b1;
            end
        end
    end

    assign sts.need_unlink = unl_reg;
    assign sts.need_link   = lnk_reg;

    logic [PW-1:0] u_p;
    logic [PW-1:0] u_n;
    logic [LW-1:0] u_l;
    logic [PW-1:0] k_t;
    assign u_p = prev_reg[s_reg];
    assign u_n = next_reg[s_reg];
    assign u_l = lvl_reg[s_reg];
    assign k_t = tail_reg[lv_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int j = 0; j < LEVELS; j++)
            begin
                head_reg[j] <= NONE;
                tail_reg[j] <= NONE;
                lcnt_reg[j] <= '0;
            end
            nid_reg  <= 16'd1;
            run_reg  <= NONE;
            swt_reg  <= '0;
            ret_reg  <= '0;
            live_reg <= '0;
            unl_reg  <= 1'b0;
            lnk_reg  <= 1'b0;
            rel_reg  <= 1'b0;
            st_reg   <= ST_OK;
            op_reg   <= '0;
        end
        else if (cmd.load)
        begin
            op_reg  <= operation;
            st_reg  <= ST_OK;
            unl_reg <= 1'b0;
            lnk_reg <= 1'b0;
            rel_reg <= 1'b0;
            case (operation)
                OP_ADD:
                begin
                    if (!free_ok)
                    begin
                        st_reg <= ST_FULL;
                    end
                    else
                    begin
                        s_reg             <= free_idx;
                        lv_reg            <= add_lv;
                        used_reg[free_idx] <= 1'b1;
                        tid_reg[free_idx] <= nid_reg;
                        lvl_reg[free_idx] <= add_lv;
                        sw_reg[free_idx]  <= '0;
                        nid_reg           <= nid_reg + 16'd1;
                        live_reg          <= live_reg + CW'(1);
                        lnk_reg           <= 1'b1;
                    end
                end
                OP_SELECT:
                begin
                    if (swt_reg != 16'hFFFF)
                    begin
                        swt_reg <= swt_reg + 16'd1;
                    end
                    if (!head_ok)
                    begin
                        run_reg <= NONE;
                        st_reg  <= ST_EMPTY;
                    end
                    else
                    begin
                        s_reg   <= head_idx;
                        run_reg <= PW'(head_idx);
                        if (sw_reg[head_idx] != 16'hFFFF)
                        begin
                            sw_reg[head_idx] <= sw_reg[head_idx] + 16'd1;
                        end
                    end
                end
                OP_ROTATE:
                begin
                    if (!run_ok)
                    begin
                        st_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        s_reg   <= run_idx;
                        lv_reg  <= lvl_reg[run_idx];
                        unl_reg <= 1'b1;
                        lnk_reg <= 1'b1;
                    end
                end
                OP_CANCEL:
                begin
                    if (!hit_ok)
                    begin
                        st_reg <= ST_NOT_FOUND;
                    end
                    else
                    begin
                        s_reg   <= hit_idx;
                        unl_reg <= 1'b1;
                        rel_reg <= 1'b1;
                        if (run_reg == PW'(hit_idx))
                        begin
                            run_reg <= NONE;
                        end
                    end
                end
                OP_COMPLETE:
                begin
                    if (!run_ok)
                    begin
                        st_reg <= ST_EMPTY;
                    end
                    else
                    begin
                        s_reg   <= run_idx;
                        unl_reg <= 1'b1;
                        rel_reg <= 1'b1;
                        run_reg <= NONE;
                        if (ret_reg != 16'hFFFF)
                        begin
                            ret_reg <= ret_reg + 16'd1;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_OK;
                end
            endcase
        end
        else if (cmd.unlink)
        begin
            if (u_p < NONE)
            begin
                next_reg[u_p[SW-1:0]] <= u_n;
            end
            else
            begin
                head_reg[u_l] <= u_n;
            end
            if (u_n < NONE)
            begin
                prev_reg[u_n[SW-1:0]] <= u_p;
            end
            else
            begin
                tail_reg[u_l] <= u_p;
            end
            if (lcnt_reg[u_l] != '0)
            begin
                lcnt_reg[u_l] <= lcnt_reg[u_l] - CW'(1);
            end
            prev_reg[s_reg] <= NONE;
            next_reg[s_reg] <= NONE;
            if (rel_reg)
            begin
                used_reg[s_reg] <= 1'b0;
                if (live_reg != '0)
                begin
                    live_reg <= live_reg - CW'(1);
                end
            end
        end
        else if (cmd.link)
        begin
            prev_reg[s_reg] <= k_t;
            next_reg[s_reg] <= NONE;
            if (k_t < NONE)
            begin
                next_reg[k_t[SW-1:0]] <= PW'(s_reg);
            end
            else
            begin
                head_reg[lv_reg] <= PW'(s_reg);
            end
            tail_reg[lv_reg] <= PW'(s_reg);
            lcnt_reg[lv_reg] <= lcnt_reg[lv_reg] + CW'(1);
        end
    end

    logic res_ok;
    assign res_ok = (st_reg == ST_OK) && (op_reg <= 3'(OP_COMPLETE));

    always_comb
    begin
        status          = st_reg;
        slot            = res_ok ? 3'(s_reg) : 3'd0;
        task_id         = res_ok ? tid_reg[s_reg] : 16'd0;
        task_switches   = res_ok ? sw_reg[s_reg] : 16'd0;
        running_valid   = run_ok;
        running_slot    = run_ok ? 3'(run_idx) : 3'd0;
        total_switches  = swt_reg;
        completed_count = ret_reg;
        active_count    = 4'(live_reg);
    end

endmodule

// ===== design/mprq_checker.sv =====
// Port-level checker for the multilevel priority run queue, with its bind.
// Depends on multilevel_priority_run_queue_defines.svh.
`include "multilevel_priority_run_queue_defines.svh"

module mprq_props (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    `MPRQ_ASSERT_IMPL(a_one_side, clk, rst_n, m_axis_tvalid, !s_axis_tready, "ready while result held")
    `MPRQ_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `MPRQ_ASSERT_NEXT(a_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "no command in flight")
    `MPRQ_ASSERT_IMPL(a_count, clk, rst_n, m_axis_tvalid, m_axis_tdata[76:73] <= 4'd8, "active count too large")
endmodule

bind multilevel_priority_run_queue mprq_props u_mprq_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
